// ===== design/rmcu_pkg.sv =====
// ----------------------------------------------------------------------------
// rmcu_pkg
// Shared types, constants and fixed-point helpers for the mean/covariance
// estimator.
// ----------------------------------------------------------------------------
package rmcu_pkg;

  localparam int DATA_W   = 32;
  localparam int GAIN_W   = 17;
  localparam int IO_ELEMS = 4;
  localparam int ROW_W    = 2;
  localparam int DIM_DEF  = 4;
  localparam int DIM_MAX  = 8;
  localparam int K_W      = 3;
  localparam int ACC_W    = 66;

  localparam logic [GAIN_W-1:0] GAIN_ONE = 17'd65536;

  typedef enum logic [2:0] {
    OP_NONE,
    OP_LOAD,
    OP_MMUL,
    OP_MUPD,
    OP_ECALC,
    OP_CMUL1,
    OP_CMUL2,
    OP_CUPD
  } cell_op_t;

  typedef struct packed {
    cell_op_t       op;
    logic [K_W-1:0] k;
  } cell_ctl_t;

  typedef enum logic [3:0] {
    S_IDLE,
    S_LOAD,
    S_MMUL,
    S_MUPD,
    S_ECALC,
    S_CMUL1,
    S_CMUL2,
    S_CUPD,
    S_EMIT
  } state_t;

  function automatic logic signed [DATA_W-1:0] sat32(input logic signed [ACC_W-1:0] v);
    if (v > 66'sd2147483647) begin
      return 32'sh7fffffff;
    end else if (v < -66'sd2147483648) begin
      return 32'sh80000000;
    end else begin
      return v[DATA_W-1:0];
    end
  endfunction

  function automatic logic signed [ACC_W-1:0] rnd16(input logic signed [ACC_W-1:0] p);
    logic signed [ACC_W-1:0] s;
    s = p + 66'sd32768;
    return s >>> 16;
  endfunction

endpackage

// ===== design/rmcu_in_if.sv =====
// ----------------------------------------------------------------------------
// rmcu_in_if
// Sample channel: four elements, step gain and first-sample flag.
// ----------------------------------------------------------------------------
interface rmcu_in_if;
  logic                                valid;
  logic                                ready;
  logic signed [rmcu_pkg::DATA_W-1:0]  sample_e0;
  logic signed [rmcu_pkg::DATA_W-1:0]  sample_e1;
  logic signed [rmcu_pkg::DATA_W-1:0]  sample_e2;
  logic signed [rmcu_pkg::DATA_W-1:0]  sample_e3;
  logic        [rmcu_pkg::GAIN_W-1:0]  step_gain;
  logic                                first_sample;

  modport source (output valid, sample_e0, sample_e1, sample_e2, sample_e3,
                  step_gain, first_sample, input ready);
  modport sink   (input valid, sample_e0, sample_e1, sample_e2, sample_e3,
                  step_gain, first_sample, output ready);
endinterface

// ===== design/rmcu_out_if.sv =====
// ----------------------------------------------------------------------------
// rmcu_out_if
// Result channel: one estimate row per transfer.
// ----------------------------------------------------------------------------
interface rmcu_out_if;
  logic                                valid;
  logic                                ready;
  logic        [rmcu_pkg::ROW_W-1:0]   row_index;
  logic signed [rmcu_pkg::DATA_W-1:0]  mean_elem;
  logic signed [rmcu_pkg::DATA_W-1:0]  cov_c0;
  logic signed [rmcu_pkg::DATA_W-1:0]  cov_c1;
  logic signed [rmcu_pkg::DATA_W-1:0]  cov_c2;
  logic signed [rmcu_pkg::DATA_W-1:0]  cov_c3;
  logic                                last_row;

  modport source (output valid, row_index, mean_elem, cov_c0, cov_c1, cov_c2,
                  cov_c3, last_row, input ready);
  modport sink   (input valid, row_index, mean_elem, cov_c0, cov_c1, cov_c2,
                  cov_c3, last_row, output ready);
endinterface

// ===== design/recursive_mean_covariance_update_top.sv =====
// ----------------------------------------------------------------------------
// recursive_mean_covariance_update_top
// Running mean and covariance estimator built as a ring of row cells.
//
// Channel  Dir  Payload                                     Transfer
// in_ch    in   sample_e0..3, step_gain, first_sample       valid & ready
// out_ch   out  row_index, mean_elem, cov_c0..3, last_row   valid & ready
//
// A first sample loads the estimate; any other runs the mean update, the
// difference step and, per covariance column, two registered multiplies
// and a write, in every cell at once, followed by min(DIM,4) row transfers.
// A new sample is taken only once the last row has gone. Rows hold while
// out_ch stalls. Reset clears control and the estimate.
// ----------------------------------------------------------------------------
module recursive_mean_covariance_update_top #(
  parameter int DIM = rmcu_pkg::DIM_DEF
) (
  input  logic        clk,
  input  logic        rst_n,
  rmcu_in_if.sink     in_ch,
  rmcu_out_if.source  out_ch
);

  localparam int W  = rmcu_pkg::DATA_W;
  localparam int IO = rmcu_pkg::IO_ELEMS;

  logic signed [W-1:0]              x_r [IO];
  logic signed [W-1:0]              x_nxt [IO];
  logic [rmcu_pkg::GAIN_W-1:0]      g_r, g_nxt;
  logic                             in_fire;
  logic                             in_rdy;
  logic                             out_vld;
  logic [rmcu_pkg::ROW_W-1:0]       row;
  logic                             last;
  rmcu_pkg::cell_ctl_t              ctl;

  logic signed [W-1:0] ep   [DIM];
  logic signed [W-1:0] mean [DIM];
  logic signed [W-1:0] cov  [DIM][DIM];
  logic signed [W-1:0] mean_o [IO];
  logic signed [W-1:0] cov_o  [IO][IO];

  assign in_fire = in_ch.valid & in_rdy;

  always_comb begin
    x_nxt = x_r;
    g_nxt = g_r;
    if (in_fire) begin
      x_nxt[0] = in_ch.sample_e0;
      x_nxt[1] = in_ch.sample_e1;
      x_nxt[2] = in_ch.sample_e2;
      x_nxt[3] = in_ch.sample_e3;
      g_nxt    = (in_ch.step_gain > rmcu_pkg::GAIN_ONE) ? rmcu_pkg::GAIN_ONE
                                                        : in_ch.step_gain;
    end
  end

  always_ff @(posedge clk) begin
    x_r <= x_nxt;
    g_r <= g_nxt;
  end

  rmcu_seq #(.DIM(DIM)) u_seq (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_fire  (in_fire),
    .first    (in_ch.first_sample),
    .out_fire (out_vld & out_ch.ready),
    .in_rdy   (in_rdy),
    .out_vld  (out_vld),
    .row      (row),
    .last     (last),
    .ctl      (ctl)
  );

  for (genvar i = 0; i < DIM; i++) begin : g_cell
    logic signed [W-1:0] xi;
    if (i < IO) begin : g_x
      assign xi = x_r[i];
    end else begin : g_z
      assign xi = '0;
    end
    rmcu_cell #(.DIM(DIM), .IDX(i)) u_cell (
      .clk    (clk),
      .rst_n  (rst_n),
      .ctl    (ctl),
      .x      (xi),
      .g      (g_r),
      .ep_in  (ep[(i + 1) % DIM]),
      .ep_out (ep[i]),
      .mean   (mean[i]),
      .cov    (cov[i])
    );
  end

  for (genvar r = 0; r < IO; r++) begin : g_orow
    if (r < DIM) begin : g_live
      assign mean_o[r] = mean[r];
      for (genvar c = 0; c < IO; c++) begin : g_ocol
        if (c < DIM) begin : g_cv
          assign cov_o[r][c] = cov[r][c];
        end else begin : g_cz
          assign cov_o[r][c] = '0;
        end
      end
    end else begin : g_dead
      assign mean_o[r] = '0;
      for (genvar c = 0; c < IO; c++) begin : g_ocz
        assign cov_o[r][c] = '0;
      end
    end
  end

  assign in_ch.ready      = in_rdy;
  assign out_ch.valid     = out_vld;
  assign out_ch.row_index = row;
  assign out_ch.mean_elem = mean_o[row];
  assign out_ch.cov_c0    = cov_o[row][0];
  assign out_ch.cov_c1    = cov_o[row][1];
  assign out_ch.cov_c2    = cov_o[row][2];
  assign out_ch.cov_c3    = cov_o[row][3];
  assign out_ch.last_row  = last;

endmodule

// ===== design/rmcu_cell.sv =====
// ----------------------------------------------------------------------------
// rmcu_cell
// One row of the estimate: mean element, covariance row and a ring register
// that passes difference values to the neighbouring cell.
// ----------------------------------------------------------------------------
module rmcu_cell #(
  parameter int DIM = rmcu_pkg::DIM_DEF,
  parameter int IDX = 0
) (
  input  logic                               clk,
  input  logic                               rst_n,
  input  rmcu_pkg::cell_ctl_t                ctl,
  input  logic signed [rmcu_pkg::DATA_W-1:0] x,
  input  logic        [rmcu_pkg::GAIN_W-1:0] g,
  input  logic signed [rmcu_pkg::DATA_W-1:0] ep_in,
  output logic signed [rmcu_pkg::DATA_W-1:0] ep_out,
  output logic signed [rmcu_pkg::DATA_W-1:0] mean,
  output logic signed [rmcu_pkg::DATA_W-1:0] cov [DIM]
);

  localparam int IW = (DIM > 1) ? $clog2(DIM) : 1;
  localparam int W  = rmcu_pkg::DATA_W;
  localparam int AW = rmcu_pkg::ACC_W;

  logic signed [W-1:0]  mean_r, mean_nxt;
  logic signed [W-1:0]  cov_r [DIM];
  logic signed [W-1:0]  cov_nxt [DIM];
  logic signed [W-1:0]  e_r, e_nxt;
  logic signed [W-1:0]  ep_r, ep_nxt;
  logic signed [AW-1:0] prod_r, prod_nxt;

  logic [rmcu_pkg::K_W:0] jsum;
  logic [rmcu_pkg::K_W:0] jfold;
  logic [IW-1:0]          j;
  logic signed [17:0]     gs;
  logic signed [W:0]      d;
  logic signed [W-1:0]    op;

  always_comb begin
    jsum  = (rmcu_pkg::K_W+1)'(IDX) + {1'b0, ctl.k};
    jfold = (jsum >= (rmcu_pkg::K_W+1)'(DIM)) ? jsum - (rmcu_pkg::K_W+1)'(DIM) : jsum;
    j     = jfold[IW-1:0];
    gs    = $signed({1'b0, g});
    mean_nxt = mean_r;
    cov_nxt  = cov_r;
    e_nxt    = e_r;
    ep_nxt   = ep_r;
    prod_nxt = prod_r;
    d  = '0;
    op = '0;
    case (ctl.op)
      rmcu_pkg::OP_LOAD: begin
        mean_nxt = x;
        for (int c = 0; c < DIM; c++) cov_nxt[c] = '0;
      end
      rmcu_pkg::OP_MMUL: begin
        d        = (W+1)'(x) - (W+1)'(mean_r);
        prod_nxt = AW'(d) * AW'(gs);
      end
      rmcu_pkg::OP_MUPD: begin
        mean_nxt = rmcu_pkg::sat32(AW'(mean_r) + rmcu_pkg::rnd16(prod_r));
      end
      rmcu_pkg::OP_ECALC: begin
        e_nxt  = rmcu_pkg::sat32(AW'(x) - AW'(mean_r));
        ep_nxt = e_nxt;
      end
      rmcu_pkg::OP_CMUL1: begin
        prod_nxt = AW'(e_r) * AW'(ep_r);
      end
      rmcu_pkg::OP_CMUL2: begin
        op       = rmcu_pkg::sat32(rmcu_pkg::rnd16(prod_r));
        d        = (W+1)'(op) - (W+1)'(cov_r[j]);
        prod_nxt = AW'(d) * AW'(gs);
      end
      rmcu_pkg::OP_CUPD: begin
        cov_nxt[j] = rmcu_pkg::sat32(AW'(cov_r[j]) + rmcu_pkg::rnd16(prod_r));
        ep_nxt     = ep_in;
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mean_r <= '0;
      cov_r  <= '{default: '0};
      e_r    <= '0;
      ep_r   <= '0;
      prod_r <= '0;
    end else begin
      mean_r <= mean_nxt;
      cov_r  <= cov_nxt;
      e_r    <= e_nxt;
      ep_r   <= ep_nxt;
      prod_r <= prod_nxt;
    end
  end

  assign ep_out = ep_r;
  assign mean   = mean_r;
  assign cov    = cov_r;

endmodule

// ===== design/rmcu_seq.sv =====
// ----------------------------------------------------------------------------
// rmcu_seq
// Step sequencer: walks the cells through the mean update, the difference
// ring and the covariance columns, then hands out the rows.
// ----------------------------------------------------------------------------
module rmcu_seq #(
  parameter int DIM = rmcu_pkg::DIM_DEF
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          in_fire,
  input  logic                          first,
  input  logic                          out_fire,
  output logic                          in_rdy,
  output logic                          out_vld,
  output logic [rmcu_pkg::ROW_W-1:0]    row,
  output logic                          last,
  output rmcu_pkg::cell_ctl_t           ctl
);

  localparam int ROWS = (DIM < rmcu_pkg::IO_ELEMS) ? DIM : rmcu_pkg::IO_ELEMS;

  rmcu_pkg::state_t                state_r, state_nxt;
  logic [rmcu_pkg::K_W-1:0]        k_r, k_nxt;
  logic [rmcu_pkg::ROW_W-1:0]      row_r, row_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= rmcu_pkg::S_IDLE;
      k_r     <= '0;
      row_r   <= '0;
    end else begin
      state_r <= state_nxt;
      k_r     <= k_nxt;
      row_r   <= row_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    k_nxt     = k_r;
    row_nxt   = row_r;
    in_rdy    = 1'b0;
    out_vld   = 1'b0;
    ctl.op    = rmcu_pkg::OP_NONE;
    ctl.k     = k_r;
    case (state_r)
      rmcu_pkg::S_IDLE: begin
        in_rdy = 1'b1;
        if (in_fire) begin
          state_nxt = first ? rmcu_pkg::S_LOAD : rmcu_pkg::S_MMUL;
        end
      end
      rmcu_pkg::S_LOAD: begin
        ctl.op    = rmcu_pkg::OP_LOAD;
        row_nxt   = '0;
        state_nxt = rmcu_pkg::S_EMIT;
      end
      rmcu_pkg::S_MMUL: begin
        ctl.op    = rmcu_pkg::OP_MMUL;
        state_nxt = rmcu_pkg::S_MUPD;
      end
      rmcu_pkg::S_MUPD: begin
        ctl.op    = rmcu_pkg::OP_MUPD;
        state_nxt = rmcu_pkg::S_ECALC;
      end
      rmcu_pkg::S_ECALC: begin
        ctl.op    = rmcu_pkg::OP_ECALC;
        k_nxt     = '0;
        state_nxt = rmcu_pkg::S_CMUL1;
      end
      rmcu_pkg::S_CMUL1: begin
        ctl.op    = rmcu_pkg::OP_CMUL1;
        state_nxt = rmcu_pkg::S_CMUL2;
      end
      rmcu_pkg::S_CMUL2: begin
        ctl.op    = rmcu_pkg::OP_CMUL2;
        state_nxt = rmcu_pkg::S_CUPD;
      end
      rmcu_pkg::S_CUPD: begin
        ctl.op = rmcu_pkg::OP_CUPD;
        if (k_r == rmcu_pkg::K_W'(DIM - 1)) begin
          row_nxt   = '0;
          state_nxt = rmcu_pkg::S_EMIT;
        end else begin
          k_nxt     = k_r + 1'b1;
          state_nxt = rmcu_pkg::S_CMUL1;
        end
      end
      rmcu_pkg::S_EMIT: begin
        out_vld = 1'b1;
        if (out_fire) begin
          if (row_r == rmcu_pkg::ROW_W'(ROWS - 1)) begin
            state_nxt = rmcu_pkg::S_IDLE;
          end else begin
            row_nxt = row_r + 1'b1;
          end
        end
      end
      default: begin
        state_nxt = rmcu_pkg::S_IDLE;
      end
    endcase
  end

  assign row  = row_r;
  assign last = (row_r == rmcu_pkg::ROW_W'(ROWS - 1));

endmodule

// ===== dv/rmcu_estimate_checker.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rmcu_estimate_checker
// Watches the sample and row channels, keeps its own running mean and
// covariance, and compares every row transfer against the predicted row.
// ----------------------------------------------------------------------------
module rmcu_estimate_checker
  import rmcu_pkg::*;
#(
  parameter int DIM = DIM_DEF
) (
  input  logic        clk,
  input  logic        rst_n,
  rmcu_in_if          in_ch,
  rmcu_out_if         out_ch,
  output int          fail_count,
  output int          rows_pending
);

  typedef struct {
    logic [ROW_W-1:0]         row;
    logic signed [DATA_W-1:0] mean;
    logic signed [DATA_W-1:0] cov [IO_ELEMS];
    logic                     last;
  } est_row_t;

  longint   mean_est [DIM];
  longint   cov_est [DIM*DIM];
  est_row_t row_queue [$];

  function automatic longint clip32(input longint v);
    if (v > 64'sd2147483647) return 64'sd2147483647;
    if (v < -64'sd2147483648) return -64'sd2147483648;
    return v;
  endfunction

  function automatic longint round_q16(input longint p);
    return (p + 64'sd32768) >>> 16;
  endfunction

  task automatic update_estimate(input longint x [IO_ELEMS], input longint gain,
                                 input logic first);
    longint   xs [DIM];
    longint   e [DIM];
    longint   op;
    longint   c;
    est_row_t r;
    int       nrows;
    for (int i = 0; i < DIM; i++) xs[i] = (i < IO_ELEMS) ? x[i] : 0;
    if (gain > 65536) gain = 65536;
    if (first) begin
      for (int i = 0; i < DIM; i++) mean_est[i] = xs[i];
      for (int i = 0; i < DIM*DIM; i++) cov_est[i] = 0;
    end else begin
      for (int i = 0; i < DIM; i++)
        mean_est[i] = clip32(mean_est[i] + round_q16((xs[i] - mean_est[i]) * gain));
      for (int i = 0; i < DIM; i++) e[i] = clip32(xs[i] - mean_est[i]);
      for (int i = 0; i < DIM; i++)
        for (int j = 0; j < DIM; j++) begin
          op = clip32(round_q16(e[i] * e[j]));
          c  = cov_est[i*DIM+j];
          cov_est[i*DIM+j] = clip32(c + round_q16((op - c) * gain));
        end
    end
    nrows = (DIM < IO_ELEMS) ? DIM : IO_ELEMS;
    for (int i = 0; i < nrows; i++) begin
      r.row  = i[ROW_W-1:0];
      r.mean = mean_est[i][DATA_W-1:0];
      for (int j = 0; j < IO_ELEMS; j++)
        r.cov[j] = (j < DIM) ? cov_est[i*DIM+j][DATA_W-1:0] : '0;
      r.last = (i == nrows - 1);
      row_queue.push_back(r);
    end
  endtask

  task automatic compare_field(input string name, input longint exp_v, input longint act_v);
    if (exp_v != act_v) begin
      $error("%s: expected %0d, got %0d", name, exp_v, act_v);
      fail_count++;
    end
  endtask

  initial begin
    fail_count = 0;
    for (int i = 0; i < DIM; i++) mean_est[i] = 0;
    for (int i = 0; i < DIM*DIM; i++) cov_est[i] = 0;
  end

  assign rows_pending = row_queue.size();

  always @(posedge clk) begin
    longint   x [IO_ELEMS];
    est_row_t r;
    logic signed [DATA_W-1:0] got [IO_ELEMS];
    if (rst_n) begin
      if (out_ch.valid && out_ch.ready) begin
        if (row_queue.size() == 0) begin
          $error("row transfer with no row expected");
          fail_count++;
        end else begin
          r = row_queue.pop_front();
          got[0] = out_ch.cov_c0;
          got[1] = out_ch.cov_c1;
          got[2] = out_ch.cov_c2;
          got[3] = out_ch.cov_c3;
          compare_field("row_index", r.row, out_ch.row_index);
          compare_field("mean_elem", r.mean, out_ch.mean_elem);
          for (int j = 0; j < IO_ELEMS; j++)
            compare_field($sformatf("cov_c%0d", j), r.cov[j], got[j]);
          compare_field("last_row", r.last, out_ch.last_row);
        end
      end
      if (in_ch.valid && in_ch.ready) begin
        x[0] = in_ch.sample_e0;
        x[1] = in_ch.sample_e1;
        x[2] = in_ch.sample_e2;
        x[3] = in_ch.sample_e3;
        update_estimate(x, longint'(in_ch.step_gain), in_ch.first_sample);
      end
    end
  end

endmodule

// ===== dv/tb_recursive_mean_covariance_update_top.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_recursive_mean_covariance_update_top
// Drives directed and random sample vectors with bursty valid and a stalling
// row receiver; the checker predicts every row and counts mismatches.
// ----------------------------------------------------------------------------
module tb_recursive_mean_covariance_update_top;
  import rmcu_pkg::*;

  localparam int  N_RANDOM  = 200;
  localparam longint LIMIT  = 400000;

  logic   clk;
  logic   rst_n;
  int     fail_count;
  int     rows_pending;
  longint cycle_count;

  rmcu_in_if  in_ch ();
  rmcu_out_if out_ch ();

  recursive_mean_covariance_update_top dut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch),
    .out_ch (out_ch)
  );

  rmcu_estimate_checker checker_i (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_ch        (in_ch),
    .out_ch       (out_ch),
    .fail_count   (fail_count),
    .rows_pending (rows_pending)
  );

  always begin
    clk = 1'b1;
    #2;
    clk = 1'b0;
    #2;
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > LIMIT) begin
      $display("** recursive_mean_covariance_update_top: FAILED **");
      $finish;
    end
  end

  // stall pattern for the row receiver
  int stall_mode;
  always @(negedge clk) begin
    if (!rst_n) begin
      out_ch.ready <= 1'b0;
    end else begin
      if ($urandom_range(0, 99) == 0) stall_mode = $urandom_range(0, 3);
      case (stall_mode)
        0: out_ch.ready <= 1'b1;
        1: out_ch.ready <= ($urandom_range(0, 3) != 0);
        2: out_ch.ready <= ($urandom_range(0, 1) != 0);
        default: out_ch.ready <= ($urandom_range(0, 5) == 0);
      endcase
    end
  end

  function automatic logic [DATA_W-1:0] pick_elem(input int mode);
    case (mode)
      0: return 32'h7fffffff;
      1: return 32'h80000000;
      2: return $urandom;
      3: return 32'(signed'($urandom_range(0, 2 * 65536 * 64)) - 65536 * 64);
      default: return 32'(signed'($urandom_range(0, 4 * 65536)) - 2 * 65536);
    endcase
  endfunction

  int burst_left;

  task automatic send_sample(input logic [DATA_W-1:0] e0, e1, e2, e3,
                             input logic [GAIN_W-1:0] gain, input logic first);
    if (burst_left == 0) begin
      repeat ($urandom_range(1, 30)) @(negedge clk);
      burst_left = $urandom_range(1, 6);
    end
    burst_left--;
    in_ch.valid        <= 1'b1;
    in_ch.sample_e0    <= e0;
    in_ch.sample_e1    <= e1;
    in_ch.sample_e2    <= e2;
    in_ch.sample_e3    <= e3;
    in_ch.step_gain    <= gain;
    in_ch.first_sample <= first;
    @(posedge clk);
    while (!in_ch.ready) @(posedge clk);
    @(negedge clk);
    if (burst_left == 0) in_ch.valid <= 1'b0;
  endtask

  task automatic send_random();
    int mode;
    logic [GAIN_W-1:0] gain;
    mode = $urandom_range(0, 9);
    case ($urandom_range(0, 5))
      0: gain = GAIN_ONE;
      1: gain = $urandom_range(65537, 131071);
      2: gain = $urandom_range(0, 255);
      default: gain = $urandom_range(0, 65536);
    endcase
    send_sample(pick_elem(mode < 2 ? 2 : (mode < 5 ? 3 : 4)),
                pick_elem($urandom_range(2, 4)), pick_elem($urandom_range(0, 4)),
                pick_elem($urandom_range(2, 4)), gain, ($urandom_range(0, 15) == 0));
  endtask

  initial begin
    cycle_count        = 0;
    stall_mode         = 0;
    burst_left         = 0;
    rst_n              = 1'b0;
    out_ch.ready       = 1'b0;
    in_ch.valid        = 1'b0;
    in_ch.sample_e0    = '0;
    in_ch.sample_e1    = '0;
    in_ch.sample_e2    = '0;
    in_ch.sample_e3    = '0;
    in_ch.step_gain    = '0;
    in_ch.first_sample = 1'b0;
    repeat (10) @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // directed: zero state, extremes, gain clamp, first-sample reload
    send_sample(32'h00010000, 32'hffff0000, 32'h0, 32'h00008000, 17'd32768, 1'b0);
    send_sample(32'h7fffffff, 32'h80000000, 32'h7fffffff, 32'h80000000, GAIN_ONE, 1'b0);
    send_sample(32'h80000000, 32'h7fffffff, 32'h80000000, 32'h7fffffff, GAIN_ONE, 1'b0);
    send_sample(32'h80000000, 32'h7fffffff, 32'h0, 32'hffffffff, 17'h1ffff, 1'b0);
    send_sample(32'h00020000, 32'hfffe0000, 32'h00000001, 32'hffffffff, 17'd0, 1'b1);
    send_sample(32'h00030000, 32'hfffd0000, 32'h00010000, 32'h0, 17'd0, 1'b0);
    send_sample(32'h00040000, 32'h00010000, 32'hffff8000, 32'h00000100, 17'd1, 1'b0);
    send_sample(32'h00040000, 32'h00010000, 32'hffff8000, 32'h00000100, 17'd65535, 1'b0);
    send_sample(32'h00040000, 32'h00010000, 32'hffff8000, 32'h00000100, 17'd65537, 1'b0);
    send_sample(32'h7fffffff, 32'h7fffffff, 32'h7fffffff, 32'h7fffffff, 17'h1ffff, 1'b1);
    send_sample(32'h80000000, 32'h80000000, 32'h80000000, 32'h80000000, 17'd16384, 1'b0);
    send_sample(32'h55555555, 32'haaaaaaaa, 32'h12345678, 32'hedcba987, 17'h15555, 1'b0);
    send_sample(32'haaaaaaaa, 32'h55555555, 32'hedcba987, 32'h12345678, 17'h0aaaa, 1'b1);
    send_sample(32'hffff8000, 32'h00008000, 32'hffff7fff, 32'h00007fff, 17'd49152, 1'b0);

    for (int n = 0; n < N_RANDOM; n++) send_random();
    if (burst_left != 0) in_ch.valid <= 1'b0;

    while (rows_pending != 0) @(posedge clk);
    repeat (100) @(posedge clk);
    if (fail_count == 0) begin
      $display("** recursive_mean_covariance_update_top: PASSED **");
    end else begin
      $display("** recursive_mean_covariance_update_top: FAILED **");
    end
    $finish;
  end

endmodule
